FILE: rtl/radix_trie_find_or_insert_macros.svh
// assertion macros used by the trie top level
// no dependencies
`ifndef RADIX_TRIE_FIND_OR_INSERT_MACROS_SVH
`define RADIX_TRIE_FIND_OR_INSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RT_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rt check failed");

// implication checked on the edge after the antecedent
`define RT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rt check failed");

`endif

FILE: rtl/rtrie_pkg.sv
// package for the radix trie: sizes, link codes, helper functions
// no dependencies
`default_nettype none
package rtrie_pkg;
  localparam int Nodes      = 1024;
  localparam int FanoutBits = 4;
  localparam int Fanout     = 1 << FanoutBits;
  localparam int IdxW       = $clog2(Nodes);
  localparam int LinkW      = IdxW + 1;
  localparam int LinkAw     = IdxW + FanoutBits;
  localparam int Links      = Nodes * Fanout;
  localparam int KeyW       = 64;
  localparam int LevelW     = 7;
  localparam logic [LinkW-1:0] EmptyLink = LinkW'(Nodes);

  typedef logic [KeyW-1:0] key_t;
  typedef logic [LevelW-1:0] level_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [LinkW-1:0] link_t;
  typedef logic [LinkAw-1:0] laddr_t;

  // mask keeping the top lv bits
  function automatic key_t prefix_mask(input level_t lv);
    key_t m;
    m = '0;
    if (lv >= level_t'(KeyW)) m = '1;
    else if (lv != '0) m = ~({KeyW{1'b1}} >> lv);
    return m;
  endfunction

  // child selector below the top lv bits
  function automatic logic [FanoutBits-1:0] digit_at(input key_t k, input level_t lv);
    key_t s;
    s = k << lv;
    return s[KeyW-1 -: FanoutBits];
  endfunction
endpackage
`default_nettype wire

FILE: rtl/rtrie_ram.sv
// generic single port ram with registered read
// no dependencies
`default_nettype none
module rtrie_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // read before write port: a write cycle returns the old word
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/radix_trie_find_or_insert.sv
// radix trie find-or-insert top level: sequencer, node and link memories
// depends on rtrie_pkg, rtrie_ram, radix_trie_find_or_insert_macros.svh
//
// channel | direction | signals
// request | in        | start, key (busy is an output)
// result  | out       | done, leaf_index, was_new, pool_full
//
// after reset a clearing pass writes every child link empty, busy high. a request
// visits each branch as node read, check, link read, check, the last node as node
// read, check, then a split (leading zero count, three write states) or a lone leaf
// write. an empty root goes straight to the leaf write. done rises as busy drops.
// the chain of dependent memory reads sets the pace. done pulses one cycle; no stall.
`default_nettype none
`include "radix_trie_find_or_insert_macros.svh"
module radix_trie_find_or_insert
  import rtrie_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [63:0] key,
  output logic            done,
  output logic [9:0]      leaf_index,
  output logic            was_new,
  output logic            pool_full
);
  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_NRD   = 11'b00000000100,
    S_NCHK  = 11'b00000001000,
    S_LWAIT = 11'b00000010000,
    S_LCHK  = 11'b00000100000,
    S_LZC   = 11'b00001000000,
    S_W1    = 11'b00010000000,
    S_W2    = 11'b00100000000,
    S_W3    = 11'b01000000000,
    S_W4    = 11'b10000000000
  } state_t;

  state_t state, state_next;
  key_t   kreg;
  link_t  root_index;
  logic [LinkW-1:0] nodes_used;
  idx_t   cur;
  logic   slot_root;
  laddr_t slot;
  logic [LinkAw:0] clr;
  level_t split_lv;
  key_t   diff;
  logic [$clog2(Nodes+1)-1:0] free_nodes;
  logic   hit;
  logic   done_next;

  // node memory
  logic   n_we;
  idx_t   n_addr;
  key_t   n_rkey, n_wkey;
  level_t n_rlv, n_wlv, lv;
  rtrie_ram #(.Width(KeyW + LevelW), .Depth(Nodes)) u_node (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata({n_wkey, n_wlv}), .rdata({n_rkey, n_rlv})
  );

  // link memory
  logic   l_we;
  laddr_t l_addr;
  link_t  l_wdata, l_rdata, l_val;
  rtrie_ram #(.Width(LinkW), .Depth(Links)) u_link (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
  );

  assign free_nodes = (nodes_used < LinkW'(Nodes)) ?
                      ($bits(free_nodes))'(Nodes - 32'(nodes_used)) : '0;
  assign lv = (n_rlv > level_t'(KeyW)) ? level_t'(KeyW) : n_rlv;
  assign hit = ((kreg ^ n_rkey) & prefix_mask(lv)) == '0;
  assign l_val = (l_rdata < EmptyLink) ? l_rdata : EmptyLink;
  assign busy = (state != S_IDLE);

  // leading zero count of the difference, rounded down to a fanout digit
  function automatic level_t lzc_digit(input key_t d);
    level_t n;
    n = level_t'(KeyW);
    for (int i = 0; i < KeyW; i++) if (d[i]) n = level_t'(KeyW - 1 - i);
    return level_t'((n / FanoutBits) * FanoutBits);
  endfunction

  idx_t new0, new1;
  assign new0 = nodes_used[IdxW-1:0];
  assign new1 = idx_t'(nodes_used + 1'b1);

  // memory port control and next state
  always_comb begin
    n_we = 1'b0; n_addr = cur; n_wkey = kreg; n_wlv = level_t'(KeyW);
    l_we = 1'b0; l_addr = slot; l_wdata = EmptyLink;
    state_next = state;
    done_next = 1'b0;
    unique case (state)
      S_CLEAR: begin
        l_we = 1'b1; l_addr = clr[LinkAw-1:0];
        if (clr == (LinkAw+1)'(Links - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (root_index >= EmptyLink) begin
            if (free_nodes < 1) done_next = 1'b1;
            else state_next = S_W4;
          end else state_next = S_NRD;
        end
      end
      S_NRD:   state_next = S_NCHK;
      S_NCHK: begin
        if (hit) begin
          if (lv == level_t'(KeyW)) begin
            done_next = 1'b1; state_next = S_IDLE;
          end else state_next = S_LWAIT;
        end else if (free_nodes < 2) begin
          done_next = 1'b1; state_next = S_IDLE;
        end else state_next = S_LZC;
      end
      S_LWAIT: state_next = S_LCHK;
      S_LCHK: begin
        if (l_val >= EmptyLink) begin
          if (free_nodes < 1) begin
            done_next = 1'b1; state_next = S_IDLE;
          end else state_next = S_W4;
        end else state_next = S_NRD;
      end
      S_LZC:   state_next = S_W1;
      S_W1: begin
        n_we = 1'b1; n_addr = new0; n_wlv = split_lv;
        l_we = 1'b1; l_addr = {new0, digit_at(n_rkey, split_lv)}; l_wdata = {1'b0, cur};
        state_next = S_W2;
      end
      S_W2: begin
        n_we = 1'b1; n_addr = new1;
        l_we = 1'b1; l_addr = {new0, digit_at(kreg, split_lv)}; l_wdata = {1'b0, new1};
        state_next = S_W3;
      end
      S_W3: begin
        l_we = !slot_root; l_wdata = {1'b0, new0};
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      S_W4: begin
        n_we = 1'b1; n_addr = new0;
        l_we = !slot_root; l_wdata = {1'b0, new0};
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr <= '0; root_index <= EmptyLink; nodes_used <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
      unique case (state)
        S_CLEAR: clr <= clr + 1'b1;
        S_IDLE: if (start) begin
          kreg <= key; slot_root <= 1'b1;
          if (root_index >= EmptyLink) begin
            if (free_nodes < 1) begin
              leaf_index <= '0; was_new <= 1'b0; pool_full <= 1'b1;
            end
          end else begin
            cur <= root_index[IdxW-1:0];
          end
        end
        S_NRD: ;
        S_NCHK: begin
          diff <= (kreg ^ n_rkey) & prefix_mask(lv);
          if (hit) begin
            if (lv == level_t'(KeyW)) begin
              leaf_index <= 10'(cur); was_new <= 1'b0; pool_full <= 1'b0;
            end else begin
              slot <= {cur, digit_at(kreg, lv)};
            end
          end else if (free_nodes < 2) begin
            leaf_index <= '0; was_new <= 1'b0; pool_full <= 1'b1;
          end
        end
        S_LWAIT: slot_root <= 1'b0;
        S_LCHK: begin
          if (l_val >= EmptyLink) begin
            if (free_nodes < 1) begin
              leaf_index <= '0; was_new <= 1'b0; pool_full <= 1'b1;
            end
          end else begin
            cur <= l_val[IdxW-1:0];
          end
        end
        S_LZC: split_lv <= lzc_digit(diff);
        S_W1: ;
        S_W2: ;
        S_W3: begin
          if (slot_root) root_index <= {1'b0, new0};
          nodes_used <= nodes_used + 2'd2;
          leaf_index <= 10'(new1); was_new <= 1'b1; pool_full <= 1'b0;
        end
        S_W4: begin
          if (slot_root) root_index <= {1'b0, new0};
          nodes_used <= nodes_used + 1'b1;
          leaf_index <= 10'(new0); was_new <= 1'b1; pool_full <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `RT_ASSERT_IMP(a_used_bound, clk, rst, 1'b1, nodes_used <= LinkW'(Nodes))
  `RT_ASSERT_IMP(a_done_idle, clk, rst, done, state == S_IDLE)
  `RT_ASSERT_NEXT(a_full_no_alloc, clk, rst, done && pool_full, $stable(nodes_used))
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench for radix_trie_find_or_insert: keyed find-or-insert transfers
// depends on rtrie_pkg and the radix_trie_find_or_insert rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_top
  import rtrie_pkg::*;
();

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [63:0] key;
  logic done;
  logic [9:0] leaf_index;
  logic was_new;
  logic pool_full;

  radix_trie_find_or_insert DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .key(key),
    .done(done), .leaf_index(leaf_index), .was_new(was_new), .pool_full(pool_full)
  );

  typedef struct packed {
    logic [9:0] leaf;
    logic       fresh;
    logic       full;
  } trie_result_t;

  // shadow trie
  int unsigned shadow_root;
  int unsigned shadow_used;
  logic [63:0] shadow_key [Nodes];
  int unsigned shadow_level [Nodes];
  int unsigned shadow_child [Links];

  key_t         pending_keys [$];
  trie_result_t expected_results [$];
  key_t         used_keys [$];
  int unsigned  fail_count;
  int unsigned  send_gap;
  bit           stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [63:0] keep_mask(int unsigned lv);
    if (lv == 0) return 64'd0;
    if (lv >= 64) return '1;
    return ~64'd0 << (64 - lv);
  endfunction

  function automatic int unsigned digit_of(logic [63:0] k, int unsigned lv);
    logic [63:0] s;
    if (lv >= 64) return 0;
    s = k << lv;
    return int'(s[63 -: FanoutBits]);
  endfunction

  function automatic int unsigned clz64(logic [63:0] v);
    int unsigned n;
    n = 0;
    while (n < 64 && !v[63 - n]) n++;
    return n;
  endfunction

  // walk the shadow trie and insert when missing
  function automatic trie_result_t find_or_insert(logic [63:0] k);
    trie_result_t r;
    bit at_root;
    int unsigned slot, t, lv, sl, br, lf, free_n, steps;
    logic [63:0] d;
    r = '0;
    at_root = 1;
    slot = 0;
    free_n = (shadow_used < Nodes) ? Nodes - shadow_used : 0;
    for (steps = 0; steps < 70; steps++) begin
      t = at_root ? shadow_root : shadow_child[slot];
      if (t >= Nodes) begin
        if (free_n < 1) begin
          r.full = 1'b1;
          return r;
        end
        lf = shadow_used++;
        shadow_key[lf] = k;
        shadow_level[lf] = 64;
        if (at_root) shadow_root = lf;
        else shadow_child[slot] = lf;
        r.leaf = lf[9:0];
        r.fresh = 1'b1;
        return r;
      end
      lv = shadow_level[t];
      d = (k ^ shadow_key[t]) & keep_mask(lv);
      if (d == 0) begin
        if (lv == 64) begin
          r.leaf = t[9:0];
          return r;
        end
        at_root = 0;
        slot = t * Fanout + digit_of(k, lv);
      end else begin
        sl = (clz64(d) / FanoutBits) * FanoutBits;
        if (free_n < 2) begin
          r.full = 1'b1;
          return r;
        end
        br = shadow_used++;
        shadow_key[br] = k;
        shadow_level[br] = sl;
        shadow_child[br * Fanout + digit_of(shadow_key[t], sl)] = t;
        if (at_root) shadow_root = br;
        else shadow_child[slot] = br;
        lf = shadow_used++;
        shadow_key[lf] = k;
        shadow_level[lf] = 64;
        shadow_child[br * Fanout + digit_of(k, sl)] = lf;
        r.leaf = lf[9:0];
        r.fresh = 1'b1;
        return r;
      end
    end
    r.full = 1'b1;
    return r;
  endfunction

  function automatic key_t rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // random key: repeat, near-neighbor of a known key, or fresh
  function automatic key_t pick_key();
    key_t k;
    int unsigned sel, b;
    sel = $urandom_range(0, 9);
    if (used_keys.size() == 0 || sel < 3) return rand_key();
    k = used_keys[$urandom_range(0, used_keys.size() - 1)];
    if (sel < 6) return k;
    b = $urandom_range(0, 63);
    if (sel < 8) return k ^ (64'd1 << b);
    return k ^ (rand_key() & ~keep_mask(b));
  endfunction

  // stimulus
  initial begin
    int i;
    shadow_root = Nodes;
    shadow_used = 0;
    for (i = 0; i < Links; i++) shadow_child[i] = Nodes;
    fail_count = 0;
    stim_done = 0;
    // directed: extremes, repeats, splits at level zero and deep levels
    pending_keys.push_back(64'd0);
    pending_keys.push_back(64'd0);
    pending_keys.push_back('1);
    pending_keys.push_back('1);
    pending_keys.push_back(64'd1);
    pending_keys.push_back(64'd2);
    pending_keys.push_back(64'h8000_0000_0000_0000);
    pending_keys.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_keys.push_back(64'h0000_0000_0000_0010);
    pending_keys.push_back(64'h0000_0000_0000_0011);
    pending_keys.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_keys.push_back(64'h5555_5555_5555_5555);
    pending_keys.push_back(64'd1);
    pending_keys.push_back(64'h8000_0000_0000_0000);
    for (i = 0; i < pending_keys.size(); i++) used_keys.push_back(pending_keys[i]);
    // random: mix of repeats, near neighbors and fresh keys
    for (i = 0; i < 536; i++) begin
      key_t k;
      k = pick_key();
      pending_keys.push_back(k);
      used_keys.push_back(k);
    end
    stim_done = 1;
  end

  // reset
  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  always @(posedge clk) begin
    int unsigned gap;
    if (rst) begin
      start <= 1'b0;
      key <= '0;
      send_gap <= 0;
    end else begin
      if (start && !busy) begin
        // transfer accepted: predict it
        expected_results.push_back(find_or_insert(key));
        void'(pending_keys.pop_front());
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        send_gap <= gap;
        if (gap == 0 && pending_keys.size() != 0) begin
          key <= pending_keys[0];
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (send_gap != 0) send_gap <= send_gap - 1;
        else if (stim_done && pending_keys.size() != 0) begin
          start <= 1'b1;
          key <= pending_keys[0];
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    trie_result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual leaf=%0d new=%0b full=%0b",
                 $time, leaf_index, was_new, pool_full);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (leaf_index !== exp_r.leaf) begin
          $display("%0t leaf_index mismatch: expected %0d actual %0d",
                   $time, exp_r.leaf, leaf_index);
          fail_count++;
        end
        if (was_new !== exp_r.fresh) begin
          $display("%0t was_new mismatch: expected %0b actual %0b",
                   $time, exp_r.fresh, was_new);
          fail_count++;
        end
        if (pool_full !== exp_r.full) begin
          $display("%0t pool_full mismatch: expected %0b actual %0b",
                   $time, exp_r.full, pool_full);
          fail_count++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_keys.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
